>>> design/yrp_pkg.sv
// Shared types, constants and helper functions for the YCbCr to RGB pixel packer.
`default_nettype none

package yrp_pkg;

  // Conversion coefficients in Q2.14.
  localparam logic signed [15:0] COEF_CR_R = 16'sd22971;
  localparam logic signed [15:0] COEF_CB_B = 16'sd29032;
  localparam logic signed [15:0] COEF_CB_G = -16'sd5631;
  localparam logic signed [15:0] COEF_CR_G = -16'sd11703;

  // Rounding bias that turns an arithmetic shift into truncation toward zero.
  localparam int unsigned      Q_FRAC_BITS = 14;
  localparam logic signed [31:0] Q_BIAS    = 32'sd16383;

  // Channel range before the byte is taken.
  localparam logic signed [19:0] CHAN_MIN = -20'sd128;
  localparam logic signed [19:0] CHAN_MAX = 20'sd127;
  localparam logic [7:0]         BYTE_MIN = 8'h80;
  localparam logic [7:0]         BYTE_MAX = 8'h7F;
  localparam logic [7:0]         SIGN_FLIP = 8'h80;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_DEPTH_24BIT   = 2'd0;
  localparam logic [1:0] CFG_IDX_SIGNED_OUTPUT = 2'd1;
  localparam logic [1:0] CFG_IDX_SET_BIT15     = 2'd2;

  // Packing positions within a group.
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_THREE = 2'd3;

  // Configuration seen by the packing stage.
  typedef struct packed {
    logic depth_24bit;
    logic signed_output;
    logic set_bit15;
  } cfg_t;

  // Registered products and luma for one item.
  typedef struct packed {
    logic signed [31:0] p_r;
    logic signed [31:0] p_g;
    logic signed [31:0] p_b;
    logic signed [15:0] y;
  } prod_t;

  // Divide a Q2.14 product by 16384 with truncation toward zero.
  function automatic logic signed [19:0] trunc_q14(input logic signed [31:0] p);
    logic signed [31:0] adj;
    adj = p + (p[31] ? Q_BIAS : 32'sd0);
    return 20'(adj >>> Q_FRAC_BITS);
  endfunction

  // Clamp a channel to -128..127, take its byte and optionally flip the top bit.
  function automatic logic [7:0] chan_byte(input logic signed [19:0] v, input logic flip);
    logic [7:0] b;
    if (v < CHAN_MIN) begin
      b = BYTE_MIN;
    end else if (v > CHAN_MAX) begin
      b = BYTE_MAX;
    end else begin
      b = v[7:0];
    end
    return flip ? (b ^ SIGN_FLIP) : b;
  endfunction

endpackage

`default_nettype wire

>>> design/yrp_mult.sv
// Coefficient multiply stage: forms the Q2.14 products and registers them.
`default_nettype none

module yrp_mult
  import yrp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] cr,
  input  wire logic signed [15:0] cb,
  input  wire logic signed [15:0] y,
  output prod_t                   prod
);

  prod_t prod_next;

  // One product per channel; the green terms are summed before truncation.
  always_comb begin
    prod_next.p_r = cr * COEF_CR_R;
    prod_next.p_b = cb * COEF_CB_B;
    prod_next.p_g = (cb * COEF_CB_G) + (cr * COEF_CR_G);
    prod_next.y   = y;
  end

  // Product register, loaded when the item moves on from the input register.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

endmodule

`default_nettype wire

>>> design/yrp_pack.sv
// Channel finish (truncate, add luma, clamp) and 15/24-bit word packing with result register.
`default_nettype none

module yrp_pack
  import yrp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  load,
  input  wire prod_t prod,
  input  wire logic  out_ready,
  output logic       out_valid,
  output logic [31:0] packed_word
);

  logic               [1:0] pack_phase;
  logic               [1:0] pack_phase_next;
  logic              [31:0] partial_word;
  logic              [31:0] partial_word_next;
  logic              [31:0] word_next;
  logic                     emit;
  logic signed       [19:0] r_val;
  logic signed       [19:0] g_val;
  logic signed       [19:0] b_val;
  logic               [7:0] rb;
  logic               [7:0] gb;
  logic               [7:0] bb;
  logic              [23:0] px24;
  logic              [15:0] px15;

  // Finish each channel and build both pixel formats.
  always_comb begin
    r_val = 20'(prod.y) + trunc_q14(prod.p_r);
    g_val = 20'(prod.y) + trunc_q14(prod.p_g);
    b_val = 20'(prod.y) + trunc_q14(prod.p_b);
    rb    = chan_byte(r_val, !cfg.signed_output);
    gb    = chan_byte(g_val, !cfg.signed_output);
    bb    = chan_byte(b_val, !cfg.signed_output);
    px24  = {bb, gb, rb};
    px15  = {cfg.set_bit15, bb[7:3], gb[7:3], rb[7:3]};
  end

  // Packing: place the pixel at the current phase and decide whether a word completes.
  always_comb begin
    word_next         = '0;
    emit              = 1'b0;
    partial_word_next = partial_word;
    pack_phase_next   = pack_phase;
    if (cfg.depth_24bit) begin
      pack_phase_next = pack_phase + 2'd1;
      case (pack_phase)
        PH_EMPTY: begin
          partial_word_next = {8'h00, px24};
        end
        PH_ONE: begin
          word_next         = partial_word | {px24[7:0], 24'h000000};
          partial_word_next = {16'h0000, px24[23:8]};
          emit              = 1'b1;
        end
        PH_TWO: begin
          word_next         = partial_word | {px24[15:0], 16'h0000};
          partial_word_next = {24'h000000, px24[23:16]};
          emit              = 1'b1;
        end
        default: begin
          word_next         = partial_word | {px24, 8'h00};
          partial_word_next = '0;
          emit              = 1'b1;
        end
      endcase
    end else begin
      if (pack_phase == PH_EMPTY) begin
        partial_word_next = {16'h0000, px15};
        pack_phase_next   = PH_ONE;
      end else begin
        word_next         = {px15, partial_word[15:0]};
        partial_word_next = '0;
        pack_phase_next   = PH_EMPTY;
        emit              = 1'b1;
      end
    end
  end

  // Packing state advances once per item that leaves the product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_phase   <= PH_EMPTY;
      partial_word <= '0;
    end else if (load) begin
      pack_phase   <= pack_phase_next;
      partial_word <= partial_word_next;
    end
  end

  // Result register: holds a finished word until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      packed_word <= word_next;
    end
  end

endmodule

`default_nettype wire

>>> design/ycbcr_to_rgb_pixel_packer_core.sv
// Top level of the YCbCr to RGB converter and 15/24-bit pixel packer.
// The block takes one pixel (Cr, Cb, Y) per cycle while in_ready is high and
// passes it through three registers: the input register, the coefficient
// product register and the result register, which offers each finished word.
// The product stage with its four 16x16 multipliers sets the pace at one
// pixel per clock unless the output stalls; in 15-bit mode every second
// pixel completes a word, in 24-bit mode three of every four do. When the
// consumer holds off a word, the stages fill and ready drops only once all
// of them are occupied. The user must write configuration only while no
// pixel is in flight; the block does not enforce this. The packing phase
// survives configuration writes and reset clears it.
`default_nettype none

module ycbcr_to_rgb_pixel_packer_core
  import yrp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic         [1:0] cfg_index,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] chroma_red,
  input  wire logic signed [15:0] chroma_blue,
  input  wire logic signed [15:0] luma,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [31:0] packed_word
);

  cfg_t               cfg;
  prod_t              prod;
  logic               s1_valid;
  logic               s2_valid;
  logic signed [15:0] cr_q;
  logic signed [15:0] cb_q;
  logic signed [15:0] y_q;
  logic               out_load_ok;
  logic               s2_move;
  logic               s1_move;
  logic               in_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IDX_DEPTH_24BIT:   cfg.depth_24bit   <= cfg_data;
        CFG_IDX_SIGNED_OUTPUT: cfg.signed_output <= cfg_data;
        CFG_IDX_SET_BIT15:     cfg.set_bit15     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: each stage moves when the one after it can take the item.
  assign out_load_ok = !out_valid || out_ready;
  assign s2_move     = s2_valid && out_load_ok;
  assign s1_move     = s1_valid && (!s2_valid || s2_move);
  assign in_ready    = !s1_valid || s1_move;
  assign in_take     = in_valid && in_ready;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      cr_q <= chroma_red;
      cb_q <= chroma_blue;
      y_q  <= luma;
    end
  end

  yrp_mult u_mult (
    .clk  (clk),
    .en   (s1_move),
    .cr   (cr_q),
    .cb   (cb_q),
    .y    (y_q),
    .prod (prod)
  );

  yrp_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .load        (s2_move),
    .prod        (prod),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .packed_word (packed_word)
  );

endmodule

`default_nettype wire

>>> design/yrp_checker.sv
// Port-level checks for the pixel packer, bound to its top level.
`default_nettype none

module yrp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] packed_word
);

  // A word that is held off stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(packed_word))
    else $error("result word changed or dropped while stalled");

  // Reset leaves no word offered.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // When the result register can move, the whole pipeline can, so input is ready.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled although the output side is free");

endmodule

bind ycbcr_to_rgb_pixel_packer_core yrp_checker u_yrp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .packed_word (packed_word)
);

`default_nettype wire
